// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/mexp_pkg.sv -----
// Shared constants and types of the modular exponentiation block
package mexp_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);
  localparam logic [WIDTH-1:0] MODULUS_RESET = WIDTH'(64'd3221225473);

  typedef logic [WIDTH-1:0] word_t;

  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    word_t result;
  } mul_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_GO,
    ST_RED_WAIT,
    ST_STEP,
    ST_PROD_GO,
    ST_PROD_WAIT,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_FINISH
  } state_t;

endpackage

// ----- hw/rtl/mexp_mulmod.sv -----
// Bit-serial modular multiplier: one double-and-add step per cycle
module mexp_mulmod import mexp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  word_t    m,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  word_t            ashift;
  word_t            acc;
  word_t            b;

  logic [WIDTH:0] dbl;
  logic [WIDTH:0] sum;
  word_t          dred;
  word_t          ared;
  word_t          acc_next;

  always_comb begin
    dbl      = {acc, 1'b0};
    dred     = (dbl >= {1'b0, m}) ? WIDTH'(dbl - {1'b0, m}) : dbl[WIDTH-1:0];
    sum      = {1'b0, dred} + {1'b0, b};
    ared     = (sum >= {1'b0, m}) ? WIDTH'(sum - {1'b0, m}) : sum[WIDTH-1:0];
    acc_next = ashift[WIDTH-1] ? ared : dred;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WIDTH - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      ashift <= req.a;
      b      <= req.b;
      acc    <= '0;
    end else if (busy) begin
      ashift <= {ashift[WIDTH-2:0], 1'b0};
      acc    <= acc_next;
    end
  end

  assign rsp.done   = done;
  assign rsp.result = acc;

endmodule

// ----- hw/rtl/mexp_ctrl.sv -----
// Square-and-multiply sequencer driving the shared multiplier
module mexp_ctrl import mexp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  word_t    base,
  input  word_t    exponent,
  input  word_t    m,
  input  logic     out_free,
  output logic     busy,
  output logic     fin_valid,
  output word_t    fin_result,
  output mul_req_t mul_req,
  input  mul_rsp_t mul_rsp
);

  state_t state;
  state_t state_next;
  word_t  sq;
  word_t  prod;
  word_t  expo;
  word_t  one_val;

  assign one_val = (m == WIDTH'(1)) ? '0 : WIDTH'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    mul_req     = '{start: 1'b0, a: prod, b: sq};
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (m == '0) ? ST_FINISH : ST_RED_GO;
        end
      end
      ST_RED_GO: begin
        mul_req    = '{start: 1'b1, a: sq, b: one_val};
        state_next = ST_RED_WAIT;
      end
      ST_RED_WAIT: begin
        if (mul_rsp.done) state_next = ST_STEP;
      end
      ST_STEP: begin
        priority if (expo == '0) state_next = ST_FINISH;
        else if (expo[0])        state_next = ST_PROD_GO;
        else                     state_next = ST_SQ_GO;
      end
      ST_PROD_GO: begin
        mul_req    = '{start: 1'b1, a: prod, b: sq};
        state_next = ST_PROD_WAIT;
      end
      ST_PROD_WAIT: begin
        if (mul_rsp.done) begin
          state_next = (expo[WIDTH-1:1] == '0) ? ST_FINISH : ST_SQ_GO;
        end
      end
      ST_SQ_GO: begin
        mul_req    = '{start: 1'b1, a: sq, b: sq};
        state_next = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (mul_rsp.done) state_next = ST_STEP;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          sq   <= base;
          expo <= exponent;
          prod <= (m == '0) ? '0 : one_val;
        end
      end
      ST_RED_WAIT, ST_SQ_WAIT: begin
        if (mul_rsp.done) sq <= mul_rsp.result;
      end
      ST_STEP: begin
        if (expo != '0 && !expo[0]) expo <= expo >> 1;
      end
      ST_PROD_WAIT: begin
        if (mul_rsp.done) begin
          prod <= mul_rsp.result;
          expo <= expo >> 1;
        end
      end
      default: begin
      end
    endcase
  end

  assign busy       = (state != ST_IDLE);
  assign fin_valid  = (state == ST_FINISH);
  assign fin_result = prod;

endmodule

// ----- hw/rtl/modular_exponentiation.sv -----
// Work per word: one reduction, one squaring per exponent bit below the top
//   set bit and one multiply per set bit, each a modular product on the
//   bit-serial multiplier of 32 steps.
// One word at a time: in_stall holds until the result leaves the controller.
// Reset: synchronous active-high rst; modulus returns to 3221225473.
module modular_exponentiation import mexp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  word_t base,
  input  word_t exponent,
  output logic  out_valid,
  input  logic  out_stall,
  output word_t power_result,
  input  logic  cfg_valid,
  output logic  cfg_ready,
  input  word_t modulus
);

  word_t    mod_value;
  logic     busy;
  logic     fin_valid;
  word_t    fin_result;
  logic     out_free;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_value <= MODULUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mod_value <= modulus;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && fin_valid) power_result <= fin_result;
  end

  mexp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (in_valid && !in_stall),
    .base       (base),
    .exponent   (exponent),
    .m          (mod_value),
    .out_free   (out_free),
    .busy       (busy),
    .fin_valid  (fin_valid),
    .fin_result (fin_result),
    .mul_req    (mul_req),
    .mul_rsp    (mul_rsp)
  );

  mexp_mulmod u_mulmod (
    .clk (clk),
    .rst (rst),
    .m   (mod_value),
    .req (mul_req),
    .rsp (mul_rsp)
  );

endmodule

// ----- hw/rtl/mexp_checker.sv -----
// Port-level checks of the modular exponentiation block
`include "assert_macros.svh"

module mexp_checker import mexp_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  in_valid,
  input logic  in_stall,
  input logic  out_valid,
  input logic  out_stall,
  input word_t power_result
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(power_result))
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `ASSERT_IMPL(a_result_after_work, clk, rst, $rose(out_valid), $past(in_stall))

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (.*);

// ----- verif/modular_exponentiation_test.sv -----
// Self-checking testbench of the modular exponentiation block: directed and random words
module modular_exponentiation_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mexp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned HOLD_CYCLES = 6000;

  typedef struct packed {
    word_t base;
    word_t exponent;
  } power_query_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  word_t base = '0;
  word_t exponent = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  word_t power_result;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  word_t cfg_modulus = '0;

  power_query_t query_queue[$];
  word_t        power_expected[$];
  power_query_t tx_word;
  word_t        rx_want;
  word_t        mod_now = MODULUS_RESET;
  int unsigned  tx_idle_pct = 0;
  int unsigned  rx_stall_pct = 0;
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;
  logic         hold_req = 1'b0;
  logic         hold_seen = 1'b0;
  int unsigned  hold_left = 0;

  modular_exponentiation i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .base         (base),
    .exponent     (exponent),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .power_result (power_result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .modulus      (cfg_modulus)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // square-and-multiply on full 64-bit products
  function automatic word_t predict_power(word_t b, word_t e, word_t m);
    logic [63:0] m64;
    logic [63:0] sq;
    logic [63:0] acc;
    word_t       ex;
    if (m == '0) return '0;
    m64 = 64'(m);
    sq  = 64'(b) % m64;
    acc = 64'd1 % m64;
    ex  = e;
    while (ex != '0) begin
      if (ex[0]) acc = (acc * sq) % m64;
      ex = ex >> 1;
      sq = (sq * sq) % m64;
    end
    return word_t'(acc);
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        power_expected.push_back(predict_power(base, exponent, mod_now));
      if (!in_valid || !in_stall) begin
        if (query_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          tx_word = query_queue.pop_front();
          base     <= tx_word.base;
          exponent <= tx_word.exponent;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and result check
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (power_expected.size() == 0) begin
          $display("%0t: power_result expected none, actual %h", $time, power_result);
          mismatches++;
        end else begin
          rx_want = power_expected.pop_front();
          if (power_result !== rx_want) begin
            $display("%0t: power_result expected %h, actual %h", $time, rx_want,
                     power_result);
            mismatches++;
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < rx_stall_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (query_queue.size() != 0 || in_valid || power_expected.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_modulus(word_t v);
    wait_drained();
    @(posedge clk);
    cfg_valid   <= 1'b1;
    cfg_modulus <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mod_now = v;
    @(negedge clk);
  endtask

  task automatic push_query(word_t b, word_t e);
    power_query_t q;
    q.base = b;
    q.exponent = e;
    query_queue.push_back(q);
  endtask

  task automatic push_random(int n);
    word_t       b;
    word_t       e;
    int unsigned nbits;
    repeat (n) begin
      case ($urandom_range(7))
        0: b = '0;
        1: b = '1;
        2: b = mod_now - 1;
        3: b = mod_now;
        default: b = $urandom;
      endcase
      nbits = $urandom_range(32);
      if (nbits == 0)
        e = '0;
      else
        e = (word_t'($urandom) >> (32 - nbits)) | (word_t'(1) << (nbits - 1));
      push_query(b, e);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset modulus
    push_query('0, '0);
    push_query('1, '0);
    push_query('0, '1);
    push_query('1, '1);
    push_query(32'd1, 32'd1);
    push_query(32'd2, 32'd1);
    push_query(mod_now, 32'd1);
    push_query(mod_now + 1, 32'd1);
    push_query(32'd2, 32'd31);
    push_query(32'd3, 32'h8000_0000);
    push_query(32'd5, 32'hAAAA_AAAA);
    push_query(32'hDEAD_BEEF, 32'h5555_5555);
    push_query(32'd7, mod_now - 1);

    write_modulus(32'd2);
    push_query('1, 32'd1);
    push_query(32'd3, '1);
    push_query(32'd4, '0);

    write_modulus('1);
    push_query('1, 32'd5);
    push_query(32'hFFFF_FFFE, '1);
    push_query(32'h1234_5678, 32'h0000_FFFF);

    // modulus of one
    write_modulus(32'd1);
    push_query(32'd9, '0);
    push_query('1, '1);

    // modulus of zero
    write_modulus('0);
    push_query(32'd9, '0);
    push_query('1, 32'd3);

    // no idling, receiver held off long enough to back up the input
    write_modulus(32'hFFFF_FFFB);
    hold_req = ~hold_req;
    push_random(64);

    // sender idling, pause midway until all results are in
    write_modulus($urandom | 32'd1);
    tx_idle_pct = 71;
    push_random(32);
    wait_drained();
    push_random(32);

    write_modulus(32'd65537);
    tx_idle_pct = 0;
    rx_stall_pct = 71;
    push_random(64);

    write_modulus($urandom_range(32'hFFFF_FFFF, 2));
    tx_idle_pct = 33;
    rx_stall_pct = 33;
    push_random(64);

    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_mulmod.sv
hw/rtl/mexp_ctrl.sv
hw/rtl/modular_exponentiation.sv
hw/rtl/mexp_checker.sv
verif/modular_exponentiation_test.sv
